/* src/smsd_pkg.sv */
//------------------------------------------------------------------------------
// smsd_pkg
// Shared types and constants of the sample mean and deviation block.
//------------------------------------------------------------------------------
`default_nettype none
package smsd_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int MAX_SAMPLES  = 1024;
	localparam int DIV_W        = 2 * SAMPLE_WIDTH;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_SINGLE  = 2'd1,
		STATUS_DROPPED = 2'd2
	} status_code_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MEAN_START,
		ST_MEAN_WAIT,
		ST_PASS,
		ST_DRAIN,
		ST_VAR_START,
		ST_VAR_WAIT,
		ST_SQRT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_var;
		logic mean_capture;
		logic pass_start;
		logic rd_en;
		logic sqrt_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_busy;
		logic pass_last;
		logic pipe_empty;
		logic sqrt_done;
		logic count_one;
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

/* src/smsd_if.sv */
//------------------------------------------------------------------------------
// smsd_in_if / smsd_out_if
// Valid/ready channels for samples and for results.
//------------------------------------------------------------------------------
`default_nettype none
interface smsd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [smsd_pkg::SAMPLE_WIDTH-1:0] sample;
	logic                                 last_sample;
	modport source (output valid, sample, last_sample, input ready);
	modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface smsd_out_if #(parameter int CNT_W = 11);
	logic                                 valid;
	logic                                 ready;
	logic signed [smsd_pkg::SAMPLE_WIDTH-1:0] mean;
	logic [smsd_pkg::SAMPLE_WIDTH-1:0]    std_deviation;
	logic [CNT_W-1:0]                     sample_count;
	logic [1:0]                           status;
	modport source (output valid, mean, std_deviation, sample_count, status, input ready);
	modport sink   (input valid, mean, std_deviation, sample_count, status, output ready);
endinterface
`default_nettype wire

/* src/smsd_div.sv */
//------------------------------------------------------------------------------
// smsd_div
// Restoring unsigned divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module smsd_div #(
	parameter int DW = 64,
	parameter int VW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [DW-1:0]      quotient
);
	localparam int CW = $clog2(DW) + 1;

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] div_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

/* src/smsd_dp.sv */
//------------------------------------------------------------------------------
// smsd_dp
// Sample buffer, running sum, deviation pass, divider and square root.
//------------------------------------------------------------------------------
`default_nettype none
module smsd_dp #(
	parameter int MAX_SAMPLES = smsd_pkg::MAX_SAMPLES,
	parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire smsd_pkg::cmd_t                       cmd,
	output smsd_pkg::stat_t                           stat,
	input  wire logic signed [smsd_pkg::SAMPLE_WIDTH-1:0] sample,
	input  wire logic                                 out_ready,
	output logic                                      out_valid,
	output logic signed [smsd_pkg::SAMPLE_WIDTH-1:0]  mean,
	output logic [smsd_pkg::SAMPLE_WIDTH-1:0]         std_deviation,
	output logic [CNT_W-1:0]                          sample_count,
	output logic [1:0]                                status
);
	localparam int SW    = smsd_pkg::SAMPLE_WIDTH;
	localparam int DW    = smsd_pkg::DIV_W;
	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int SUM_W = SW + AW + 1;
	localparam int KW    = $clog2(DW / 2);

	logic [SW-1:0]           mem [MAX_SAMPLES];
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    ovf_q;
	logic                    full;

	logic [AW-1:0]           rd_addr_q;
	logic [SW-1:0]           rd_data_s1;
	logic                    v_s1, v_s2, v_s3;
	logic [SW:0]             ud_s2;
	logic [DW-1:0]           sq_prod;
	logic [DW-1:0]           sq_s3;
	logic [DW-1:0]           sqsum_q;
	logic signed [SW-1:0]    mean_q;
	logic                    neg_q;

	logic signed [SW:0]      dev;
	logic [SW:0]             udev;
	logic [DW:0]             acc;
	logic [SUM_W-1:0]        sum_abs;
	logic [DW-1:0]           dividend;
	logic [CNT_W-1:0]        divisor;
	logic                    div_busy, div_done;
	logic [DW-1:0]           quotient;
	logic [SW-1:0]           q_low;

	logic [DW-1:0]           x_q, root_q;
	logic [KW-1:0]           k_q;
	logic                    sq_busy_q, sq_done_q;
	logic [DW-1:0]           bitv, trial, root_nx;
	logic [SW-1:0]           stddev_q;

	logic                    out_valid_q;
	logic signed [SW-1:0]    mean_out_q;
	logic [SW-1:0]           std_out_q;
	logic [CNT_W-1:0]        cnt_out_q;
	smsd_pkg::status_code_t  status_q, status_nx;

	assign full = count_q == CNT_W'(MAX_SAMPLES);

	always_ff @(posedge clk) begin
		if (cmd.load && !full)
			mem[AW'(count_q)] <= sample;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en)
			rd_data_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.out_load) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(sample);
			end
		end
	end

	assign sum_abs  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign dividend = cmd.div_var ? sqsum_q : DW'(sum_abs);
	assign divisor  = cmd.div_var ? count_q - 1'b1 : count_q;

	smsd_div #(.DW(DW), .VW(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	assign q_low = quotient[SW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_start && !cmd.div_var)
			neg_q <= sum_q[SUM_W-1];
		if (cmd.mean_capture)
			mean_q <= neg_q ? -q_low : q_low;
	end

	assign dev  = $signed({rd_data_s1[SW-1], rd_data_s1}) - $signed({mean_q[SW-1], mean_q});
	assign udev = dev[SW] ? (SW+1)'(-dev) : (SW+1)'(dev);
	assign acc  = {1'b0, sqsum_q} + {1'b0, sq_s3};
	assign sq_prod = ud_s2[SW-1:0] * ud_s2[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_start)
			rd_addr_q <= '0;
		else if (cmd.rd_en)
			rd_addr_q <= rd_addr_q + 1'b1;
		ud_s2 <= udev;
		sq_s3 <= ud_s2[SW] ? '1 : sq_prod;
		if (cmd.pass_start)
			sqsum_q <= '0;
		else if (v_s3)
			sqsum_q <= acc[DW] ? '1 : acc[DW-1:0];
	end

	assign bitv    = DW'(1) << {k_q, 1'b0};
	assign trial   = root_q + bitv;
	assign root_nx = (x_q >= trial) ? (root_q >> 1) + bitv : root_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
		end else begin
			sq_done_q <= 1'b0;
			if (cmd.sqrt_start) begin
				sq_busy_q <= 1'b1;
			end else if (sq_busy_q && k_q == '0) begin
				sq_busy_q <= 1'b0;
				sq_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_start)
			stddev_q <= '0;
		if (cmd.sqrt_start) begin
			x_q    <= quotient;
			root_q <= '0;
			k_q    <= '1;
		end else if (sq_busy_q) begin
			if (x_q >= trial)
				x_q <= x_q - trial;
			root_q <= root_nx;
			k_q    <= k_q - 1'b1;
			if (k_q == '0)
				stddev_q <= root_nx[SW-1:0];
		end
	end

	always_comb begin
		if (ovf_q)
			status_nx = smsd_pkg::STATUS_DROPPED;
		else if (count_q == CNT_W'(1))
			status_nx = smsd_pkg::STATUS_SINGLE;
		else
			status_nx = smsd_pkg::STATUS_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_out_q <= mean_q;
			std_out_q  <= stddev_q;
			cnt_out_q  <= count_q;
			status_q   <= status_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign mean          = mean_out_q;
	assign std_deviation = std_out_q;
	assign sample_count  = cnt_out_q;
	assign status        = status_q;

	assign stat.div_done   = div_done;
	assign stat.div_busy   = div_busy;
	assign stat.pass_last  = CNT_W'(rd_addr_q) == count_q - 1'b1;
	assign stat.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign stat.sqrt_done  = sq_done_q;
	assign stat.count_one  = count_q == CNT_W'(1);
	assign stat.out_busy   = out_valid_q && !out_ready;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES)) else $error("sample count beyond capacity");
	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> CNT_W'(rd_addr_q) < count_q) else $error("read of unwritten entry");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy) else $error("divider restarted while busy");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.out_busy) else $error("result overwritten");
endmodule
`default_nettype wire

/* src/smsd_ctrl.sv */
//------------------------------------------------------------------------------
// smsd_ctrl
// Sequencer: load, mean division, deviation pass, variance, root, result.
//------------------------------------------------------------------------------
`default_nettype none
module smsd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_last,
	output logic                 in_ready,
	input  wire smsd_pkg::stat_t stat,
	output smsd_pkg::cmd_t       cmd
);
	smsd_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= smsd_pkg::ST_LOAD;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			smsd_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && in_last)
					state_nx = smsd_pkg::ST_MEAN_START;
			end
			smsd_pkg::ST_MEAN_START: begin
				cmd.div_start = 1'b1;
				state_nx      = smsd_pkg::ST_MEAN_WAIT;
			end
			smsd_pkg::ST_MEAN_WAIT: begin
				if (stat.div_done) begin
					cmd.mean_capture = 1'b1;
					cmd.pass_start   = 1'b1;
					state_nx         = smsd_pkg::ST_PASS;
				end
			end
			smsd_pkg::ST_PASS: begin
				cmd.rd_en = 1'b1;
				if (stat.pass_last)
					state_nx = smsd_pkg::ST_DRAIN;
			end
			smsd_pkg::ST_DRAIN: begin
				if (stat.pipe_empty)
					state_nx = stat.count_one ? smsd_pkg::ST_DONE : smsd_pkg::ST_VAR_START;
			end
			smsd_pkg::ST_VAR_START: begin
				cmd.div_start = 1'b1;
				cmd.div_var   = 1'b1;
				state_nx      = smsd_pkg::ST_VAR_WAIT;
			end
			smsd_pkg::ST_VAR_WAIT: begin
				if (stat.div_done) begin
					cmd.sqrt_start = 1'b1;
					state_nx       = smsd_pkg::ST_SQRT;
				end
			end
			smsd_pkg::ST_SQRT: begin
				if (stat.sqrt_done)
					state_nx = smsd_pkg::ST_DONE;
			end
			smsd_pkg::ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = smsd_pkg::ST_LOAD;
				end
			end
			default: state_nx = smsd_pkg::ST_LOAD;
		endcase
	end
endmodule
`default_nettype wire

/* src/sample_mean_and_std_deviation.sv */
//------------------------------------------------------------------------------
// sample_mean_and_std_deviation
// Two-pass mean and sample standard deviation of signed Q16.16 samples.
//------------------------------------------------------------------------------
// Samples are taken one per cycle while the block collects a set, up to
// MAX_SAMPLES of them; further samples are dropped and flagged. After the
// request marked last, input stalls while one shared 64-bit divider forms
// the mean, the deviation pass reads the buffer one entry per cycle and then
// drains a three-stage pipeline, the divider forms the variance and the
// square root takes 32 steps; a single sample skips the variance and the
// root. A finished result waits in an output register while the next set
// loads; a set that finishes while that register is still held stalls the
// input until the result is taken.
`default_nettype none
module sample_mean_and_std_deviation #(
	parameter int MAX_SAMPLES = smsd_pkg::MAX_SAMPLES,
	parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
	input wire logic  clk,
	input wire logic  arst_n,
	smsd_in_if.sink   samples,
	smsd_out_if.source results
);
	smsd_pkg::cmd_t  cmd;
	smsd_pkg::stat_t stat;

	smsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_last  (samples.last_sample),
		.in_ready (samples.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	smsd_dp #(.MAX_SAMPLES(MAX_SAMPLES), .CNT_W(CNT_W)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.sample        (samples.sample),
		.out_ready     (results.ready),
		.out_valid     (results.valid),
		.mean          (results.mean),
		.std_deviation (results.std_deviation),
		.sample_count  (results.sample_count),
		.status        (results.status)
	);
endmodule
`default_nettype wire
